>>> rtl/core/fxa_pkg.sv
// Shared types and constants for the Q24.8 fixed-point arithmetic unit.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package fxa_pkg;

  localparam int WORD_W  = 32;
  localparam int MUL_W   = 2 * WORD_W;
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;

  localparam logic [WORD_W-1:0] POS_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic [WORD_W-1:0] NEG_MIN = {1'b1, {(WORD_W-1){1'b0}}};

  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,
    OP_SUB  = 4'd1,
    OP_MUL  = 4'd2,
    OP_DIV  = 4'd3,
    OP_MIN  = 4'd4,
    OP_MAX  = 4'd5,
    OP_INC  = 4'd6,
    OP_DEC  = 4'd7,
    OP_ITOF = 4'd8,
    OP_FTOI = 4'd9
  } op_t;

  // How the back end treats a word.
  typedef enum logic [1:0] {
    CLS_DIRECT = 2'd0,
    CLS_MUL    = 2'd1,
    CLS_DIV    = 2'd2
  } cls_t;

  typedef struct packed {
    logic [3:0]               operation;
    logic signed [WORD_W-1:0] operand_a;
    logic signed [WORD_W-1:0] operand_b;
  } in_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] result_value;
    logic                     a_less;
    logic                     a_equal;
    logic                     a_greater;
    logic                     overflow;
    logic                     divide_by_zero;
  } out_t;

  // Classified word handed from the front end to the back end.
  typedef struct packed {
    cls_t              cls;
    logic              neg;
    logic [WORD_W-1:0] mag_a;
    logic [WORD_W-1:0] mag_b;
    logic [WORD_W-1:0] direct;
    logic              lt;
    logic              eq;
    logic              gt;
    logic              dz;
  } job_t;

endpackage

>>> rtl/core/fxa_front.sv
// Front end: accepts input words, compares operands, works out the simple
// operations and classifies multiply and divide. Depends on fxa_pkg.
`timescale 1ns / 1ps

module fxa_front import fxa_pkg::*; #(
  parameter int FRACTION_BITS = 8
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic job_valid,
  input  logic job_full,
  output job_t job
);

  logic              f_valid_r, f_valid_nxt;
  job_t              job_r, job_nxt;
  logic [WORD_W-1:0] a_u, b_u;
  logic              lt, gt;
  logic              take;

  assign a_u  = in_data.operand_a;
  assign b_u  = in_data.operand_b;
  assign lt   = in_data.operand_a < in_data.operand_b;
  assign gt   = in_data.operand_a > in_data.operand_b;

  // The holding register is free unless the queue refuses its word.
  assign in_stall    = f_valid_r && job_full;
  assign take        = in_valid && !in_stall;
  assign f_valid_nxt = take || (f_valid_r && job_full);

  always_comb begin
    job_nxt.lt     = lt;
    job_nxt.gt     = gt;
    job_nxt.eq     = (a_u == b_u);
    job_nxt.neg    = a_u[WORD_W-1] ^ b_u[WORD_W-1];
    job_nxt.mag_a  = a_u[WORD_W-1] ? (~a_u + 1'b1) : a_u;
    job_nxt.mag_b  = b_u[WORD_W-1] ? (~b_u + 1'b1) : b_u;
    job_nxt.dz     = 1'b0;
    job_nxt.cls    = CLS_DIRECT;
    job_nxt.direct = '0;
    unique case (op_t'(in_data.operation))
      OP_ADD:  job_nxt.direct = a_u + b_u;
      OP_SUB:  job_nxt.direct = a_u - b_u;
      OP_MUL:  job_nxt.cls = CLS_MUL;
      OP_DIV: begin
        if (b_u == '0) begin
          job_nxt.dz     = 1'b1;
          job_nxt.direct = a_u[WORD_W-1] ? NEG_MIN : POS_MAX;
        end else begin
          job_nxt.cls = CLS_DIV;
        end
      end
      OP_MIN:  job_nxt.direct = lt ? a_u : b_u;
      OP_MAX:  job_nxt.direct = gt ? a_u : b_u;
      OP_INC:  job_nxt.direct = a_u + 1'b1;
      OP_DEC:  job_nxt.direct = a_u - 1'b1;
      OP_ITOF: job_nxt.direct = a_u << FRACTION_BITS;
      OP_FTOI: job_nxt.direct = in_data.operand_a >>> FRACTION_BITS;
      default: job_nxt.direct = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else begin
      f_valid_r <= f_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      job_r <= job_nxt;
    end
  end

  assign job_valid = f_valid_r;
  assign job       = job_r;

endmodule

>>> rtl/core/fxa_queue.sv
// Short first-in first-out queue of classified words between the front
// and back ends. Depends on fxa_pkg.
`timescale 1ns / 1ps

module fxa_queue import fxa_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output job_t pop_job,
  output logic empty
);

  job_t            q_mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_AW:0]   count_r, count_nxt;
  logic            do_push, do_pop;

  assign full    = (count_r == (Q_AW+1)'(Q_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_job = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (Q_AW+1)'(do_push) - (Q_AW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

>>> rtl/core/fxa_back.sv
// Back end: pipelined multiply and divide with rounding and saturation,
// and the output register. Depends on fxa_pkg.
`timescale 1ns / 1ps

module fxa_back import fxa_pkg::*; #(
  parameter int FRACTION_BITS = 8
) (
  input  logic clk,
  input  logic rst_n,
  input  logic q_empty,
  input  job_t q_job,
  output logic q_pop,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  localparam int NUM_W = WORD_W + FRACTION_BITS;
  localparam int LAST  = NUM_W + 1;
  localparam logic [MUL_W:0] HALF = (MUL_W+1)'(1) << (FRACTION_BITS - 1);

  logic              vld_r [0:LAST];
  job_t              job_r [0:LAST];
  logic [NUM_W-1:0]  num_r [0:LAST];
  logic [WORD_W-1:0] rem_r [0:LAST];
  logic [MUL_W-1:0]  big_r [0:LAST];

  logic              out_valid_r;
  out_t              out_data_r, out_data_nxt;
  logic              adv;

  // The whole pipeline moves together whenever the output register frees.
  assign adv   = !out_valid_r || !out_stall;
  assign q_pop = adv && !q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= !q_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      job_r[0] <= q_job;
      num_r[0] <= {q_job.mag_a, {FRACTION_BITS{1'b0}}};
      rem_r[0] <= '0;
      big_r[0] <= '0;
    end
  end

  for (genvar k = 0; k < LAST; k++) begin : g_stage
    logic [NUM_W-1:0]  num_n;
    logic [WORD_W-1:0] rem_n;
    logic [MUL_W-1:0]  big_n;
    logic [WORD_W:0]   trial;
    logic [WORD_W:0]   dvs;
    logic [MUL_W:0]    rsum;

    assign trial = {rem_r[k], num_r[k][NUM_W-1]};
    assign dvs   = {1'b0, job_r[k].mag_b};
    assign rsum  = {1'b0, big_r[k]} + HALF;

    always_comb begin
      num_n = num_r[k];
      rem_n = rem_r[k];
      big_n = big_r[k];
      if (job_r[k].cls == CLS_DIV) begin
        if (k < NUM_W) begin
          // One restoring quotient bit per stage.
          num_n = num_r[k] << 1;
          if (trial >= dvs) begin
            rem_n = WORD_W'(trial - dvs);
            big_n = {big_r[k][MUL_W-2:0], 1'b1};
          end else begin
            rem_n = trial[WORD_W-1:0];
            big_n = {big_r[k][MUL_W-2:0], 1'b0};
          end
        end else if ({rem_r[k], 1'b0} >= dvs) begin
          // Remainder at least half the divisor: round away from zero.
          big_n = big_r[k] + 1'b1;
        end
      end else if (job_r[k].cls == CLS_MUL) begin
        if (k == 0) begin
          big_n = {{WORD_W{1'b0}}, job_r[k].mag_a} * {{WORD_W{1'b0}}, job_r[k].mag_b};
        end else if (k == 1) begin
          big_n = MUL_W'(rsum >> FRACTION_BITS);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (adv) begin
        vld_r[k+1] <= vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        job_r[k+1] <= job_r[k];
        num_r[k+1] <= num_n;
        rem_r[k+1] <= rem_n;
        big_r[k+1] <= big_n;
      end
    end
  end

  // Saturate, apply the sign and pick the result for the last stage's word.
  always_comb begin
    logic [WORD_W-1:0] lim;
    logic [WORD_W-1:0] mag;
    logic              sat;
    lim = job_r[LAST].neg ? NEG_MIN : POS_MAX;
    sat = (big_r[LAST][MUL_W-1:WORD_W] != '0) || (big_r[LAST][WORD_W-1:0] > lim);
    mag = sat ? lim : big_r[LAST][WORD_W-1:0];
    out_data_nxt.a_less         = job_r[LAST].lt;
    out_data_nxt.a_equal        = job_r[LAST].eq;
    out_data_nxt.a_greater      = job_r[LAST].gt;
    out_data_nxt.divide_by_zero = job_r[LAST].dz;
    if (job_r[LAST].cls == CLS_DIRECT) begin
      out_data_nxt.result_value = job_r[LAST].direct;
      out_data_nxt.overflow     = 1'b0;
    end else begin
      out_data_nxt.result_value = job_r[LAST].neg ? (~mag + 1'b1) : mag;
      out_data_nxt.overflow     = sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vld_r[LAST];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> rtl/core/q24_8_fixed_point_alu.sv
// Top level of the signed Q24.8 fixed-point arithmetic unit.
// Depends on fxa_pkg, fxa_front, fxa_queue and fxa_back.
//
// This unit takes one word per cycle, each carrying an operation code and
// two signed raw operands with FRACTION_BITS fraction bits, and returns one
// result word per input word, in order. Add, subtract, increment, decrement
// and integer-to-fixed wrap; fixed-to-integer is an arithmetic right shift.
// Multiply and divide are exact, rounded to nearest with ties away from
// zero, and saturate with the overflow flag set; a divide by zero saturates
// by the sign of operand_a and raises divide_by_zero. The less, equal and
// greater flags always compare operand_a with operand_b as signed numbers,
// and unused operation codes give a result of zero. Sustained throughput
// is one word per clock while nothing stalls. Every word travels the same
// pipeline: from the edge that accepts it, the word passes the front
// holding register, one queue slot, the back end's input stage, the
// divider's one-quotient-bit-per-stage array of 32 + FRACTION_BITS
// stages plus its rounding stage, and the output register. A stall on the
// output freezes the back-end pipeline; the four-word queue lets the front
// keep accepting meanwhile, and in_stall rises only once the queue and the
// front register are full.
`timescale 1ns / 1ps

module q24_8_fixed_point_alu import fxa_pkg::*; #(
  parameter int FRACTION_BITS = 8
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  logic job_valid;
  logic job_full;
  job_t front_job;
  logic q_pop;
  logic q_empty;
  job_t q_job;

  fxa_front #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .job_valid(job_valid),
    .job_full (job_full),
    .job      (front_job)
  );

  fxa_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (job_valid),
    .push_job(front_job),
    .full    (job_full),
    .pop     (q_pop),
    .pop_job (q_job),
    .empty   (q_empty)
  );

  fxa_back #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_job    (q_job),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule

>>> rtl/core/fxa_checker.sv
// Port-level checks for the fixed-point arithmetic unit, bound to its top
// level. Depends on fxa_pkg and q24_8_fixed_point_alu.
`timescale 1ns / 1ps

module fxa_checker import fxa_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result word changed or vanished");

  a_cmp_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot({out_data.a_less, out_data.a_equal, out_data.a_greater}))
    else $error("comparison flags not exactly one");

  a_flag_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.overflow && out_data.divide_by_zero))
    else $error("overflow and divide by zero both set");

  a_dz_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.divide_by_zero |->
      (out_data.result_value == POS_MAX) || (out_data.result_value == NEG_MIN))
    else $error("divide by zero result not saturated");

  a_ovf_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.overflow |->
      (out_data.result_value == POS_MAX) || (out_data.result_value == NEG_MIN))
    else $error("overflow result not saturated");

endmodule

bind q24_8_fixed_point_alu fxa_checker u_fxa_checker (.*);

>>> tb/q24_8_fixed_point_alu_tb.sv
// Self-checking testbench for the Q24.8 fixed-point arithmetic unit.
// Depends on fxa_pkg and q24_8_fixed_point_alu; predicts every result word in-line.
`timescale 1ns / 1ps

module q24_8_fixed_point_alu_tb;
  import fxa_pkg::*;

  localparam int FRAC      = 8;
  localparam int LATENCY   = 32 + FRAC + 5;
  localparam int IDLE_LIMIT = 4000;
  localparam int RANDOM_WORDS = 1100;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  // Words waiting to be offered, and the results that they should produce.
  in_t  send_q[$];
  out_t result_q[$];
  int   error_count = 0;
  int   results_seen = 0;
  int   idle_cycles = 0;
  bit   stimulus_done = 1'b0;
  // Set at the rising edge that took the offered word.
  bit   in_taken = 1'b0;
  // Stall controls set by the stimulus thread for the receiver and the sender.
  int   hold_cycles = 0;
  bit   drain_pause = 1'b0;

  always #6 clk = ~clk;

  q24_8_fixed_point_alu #(.FRACTION_BITS(FRAC)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // Magnitude of a word, as an unsigned 64-bit number.
  function automatic logic [63:0] mag_of(input logic [31:0] v);
    mag_of = v[31] ? 64'(-$signed({32'd0, v}) & 64'hFFFF_FFFF) : {32'd0, v};
    if (v[31]) mag_of = {32'd0, 32'(~v + 32'd1)};
    if (v == 32'h8000_0000) mag_of = 64'h8000_0000;
  endfunction

  // Saturate a rounded magnitude to the signed word range, with its sign applied.
  function automatic logic [31:0] saturate(input logic [127:0] q, input bit neg,
                                           output bit ovf);
    logic [127:0] limit;
    limit = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
    ovf = 1'b0;
    if (q > limit) begin
      ovf = 1'b1;
      q = limit;
    end
    saturate = neg ? 32'(-q[31:0]) : q[31:0];
  endfunction

  // Works out the result word that the unit should return for one operation.
  function automatic out_t predict_result(input in_t w);
    out_t r;
    logic [31:0] a, b;
    logic [127:0] x, y, p, q, rem;
    bit neg, ovf;
    a = w.operand_a;
    b = w.operand_b;
    r = '0;
    r.a_less    = $signed(a) < $signed(b);
    r.a_equal   = a == b;
    r.a_greater = $signed(a) > $signed(b);
    neg = a[31] ^ b[31];
    x = 128'(mag_of(a));
    y = 128'(mag_of(b));
    case (w.operation)
      OP_ADD:  r.result_value = a + b;
      OP_SUB:  r.result_value = a - b;
      OP_MUL: begin
        // Rounding to nearest on the magnitude gives ties away from zero.
        p = x * y + (128'd1 << (FRAC - 1));
        r.result_value = saturate(p >> FRAC, neg, ovf);
        r.overflow = ovf;
      end
      OP_DIV: begin
        if (b == 32'd0) begin
          r.divide_by_zero = 1'b1;
          r.result_value = a[31] ? NEG_MIN : POS_MAX;
        end else begin
          q = (x << FRAC) / y;
          rem = (x << FRAC) % y;
          if (rem >= y - rem) q = q + 1;
          r.result_value = saturate(q, neg, ovf);
          r.overflow = ovf;
        end
      end
      OP_MIN:  r.result_value = r.a_less ? a : b;
      OP_MAX:  r.result_value = r.a_greater ? a : b;
      OP_INC:  r.result_value = a + 32'd1;
      OP_DEC:  r.result_value = a - 32'd1;
      OP_ITOF: r.result_value = a << FRAC;
      OP_FTOI: r.result_value = $signed(a) >>> FRAC;
      default: r.result_value = '0;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    $display("ERROR at %0t: %s got %h expected %h", $time, what, got, want);
  endtask

  function automatic logic [31:0] random_operand();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF - $urandom_range(0, 3);
      1: return 32'h8000_0000 + $urandom_range(0, 3);
      2: return 32'($signed($urandom_range(0, 16)) - 8);
      3: return $urandom_range(0, 32'h0000_FFFF);
      4: return -$urandom_range(0, 32'h0000_FFFF);
      default: return $urandom;
    endcase
  endfunction

  // Sender: offers queued words in bursts of random length, with random gaps.
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_taken) begin
        // The offered word stays put until it is taken.
      end else begin
        if (in_valid) void'(send_q.pop_front());
        if (gap_left > 0 || drain_pause || send_q.size() == 0) begin
          if (gap_left > 0) gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_data  <= send_q[0];
          if (burst_left > 0) begin
            burst_left <= burst_left - 1;
          end else begin
            burst_left <= $urandom_range(0, 30);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  // Receiver: its own stall pattern, plus a long hold-off on request.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < (($time / 20000) % 2 ? 0 : 30));
    end
  end

  // Monitor: predicts accepted inputs and checks accepted results in order.
  always @(posedge clk) begin
    if (rst_n) begin
      in_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) result_q.push_back(predict_result(in_data));
      if (out_valid && !out_stall) begin
        results_seen++;
        if (result_q.size() == 0) begin
          report_mismatch("unexpected result word", out_data.result_value, '0);
        end else begin
          out_t want;
          want = result_q.pop_front();
          if (out_data.result_value !== want.result_value)
            report_mismatch("result_value", out_data.result_value, want.result_value);
          if (out_data.a_less !== want.a_less)
            report_mismatch("a_less", out_data.a_less, want.a_less);
          if (out_data.a_equal !== want.a_equal)
            report_mismatch("a_equal", out_data.a_equal, want.a_equal);
          if (out_data.a_greater !== want.a_greater)
            report_mismatch("a_greater", out_data.a_greater, want.a_greater);
          if (out_data.overflow !== want.overflow)
            report_mismatch("overflow", out_data.overflow, want.overflow);
          if (out_data.divide_by_zero !== want.divide_by_zero)
            report_mismatch("divide_by_zero", out_data.divide_by_zero,
                            want.divide_by_zero);
        end
      end
      // Watchdog: counts cycles in which no word moves on either side.
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (!stimulus_done || result_q.size() != 0) begin
        idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("Timeout with %0d results outstanding", result_q.size());
          $display("Simulation FAILED");
          $finish;
        end
      end
    end
  end

  function automatic in_t make_word(input op_t op, input logic [31:0] a,
                                    input logic [31:0] b);
    in_t w;
    w.operation = op;
    w.operand_a = a;
    w.operand_b = b;
    return w;
  endfunction

  initial begin
    in_t w;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: extremes of the operands, every operation and two unused codes.
    send_q.push_back(make_word(OP_ADD, POS_MAX, 32'd1));
    send_q.push_back(make_word(OP_SUB, NEG_MIN, 32'd1));
    send_q.push_back(make_word(OP_MUL, POS_MAX, POS_MAX));
    send_q.push_back(make_word(OP_MUL, NEG_MIN, NEG_MIN));
    send_q.push_back(make_word(OP_MUL, NEG_MIN, 32'h100));
    send_q.push_back(make_word(OP_MUL, 32'h80, 32'h1));
    send_q.push_back(make_word(OP_MUL, 32'hFFFF_FF80, 32'h1));
    send_q.push_back(make_word(OP_DIV, 32'h100, 32'd0));
    send_q.push_back(make_word(OP_DIV, 32'd0, 32'd0));
    send_q.push_back(make_word(OP_DIV, NEG_MIN, 32'd0));
    send_q.push_back(make_word(OP_DIV, NEG_MIN, 32'hFFFF_FF00));
    send_q.push_back(make_word(OP_DIV, NEG_MIN, 32'h100));
    send_q.push_back(make_word(OP_DIV, 32'd1, 32'd2));
    send_q.push_back(make_word(OP_DIV, POS_MAX, 32'd1));
    send_q.push_back(make_word(OP_MIN, NEG_MIN, POS_MAX));
    send_q.push_back(make_word(OP_MAX, NEG_MIN, POS_MAX));
    send_q.push_back(make_word(OP_MAX, 32'd5, 32'd5));
    send_q.push_back(make_word(OP_INC, POS_MAX, '0));
    send_q.push_back(make_word(OP_DEC, NEG_MIN, '1));
    send_q.push_back(make_word(OP_ITOF, 32'h00FF_FFFF, '0));
    send_q.push_back(make_word(OP_FTOI, 32'hFFFF_FF01, '0));
    w = make_word(OP_ADD, '1, '0);
    w.operation = 4'hF;
    send_q.push_back(w);
    w.operation = 4'hA;
    send_q.push_back(w);

    // Random part, with a long receiver hold-off to fill the queue and stall the sender.
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      w.operation = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(10, 15))
                                                 : 4'($urandom_range(0, 9));
      w.operand_a = random_operand();
      w.operand_b = ($urandom_range(0, 19) == 0) ? 32'd0 : random_operand();
      send_q.push_back(w);
      if (i == 400) begin
        wait (send_q.size() < 300);
        @(negedge clk);
        hold_cycles <= 200;
      end
      if (i == 800) begin
        // Let the sender run dry and wait for every result before going on.
        wait (send_q.size() == 0);
        @(negedge clk);
        drain_pause <= 1'b1;
        wait (result_q.size() == 0);
        @(negedge clk);
        drain_pause <= 1'b0;
      end
    end

    wait (send_q.size() == 0 && !in_valid);
    stimulus_done = 1'b1;
    wait (result_q.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);

    $display("Checked %0d result words over all ten operations, unused codes,",
             results_seen);
    $display("divide by zero, saturation and rounding ties, with stalls on both sides.");
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
